@@ rtl/smfr_pkg.sv @@
// Shared types and constants for the stereo multitap feedback reverb.
// Used by smfr_lane and by the top level; depends on nothing else.
`timescale 1ns / 1ps

package smfr_pkg;

    // Default depth of each delay memory, as a power of two.
    localparam int DELAY_BITS_DEF = 12;

    localparam int SAMPLE_W = 16;
    localparam int OFFSET_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_ONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TWO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WET      = 2'd3;

    // Register values after reset.
    localparam logic [OFFSET_W-1:0]        TAP_ONE_RST  = 12'd1228;
    localparam logic [OFFSET_W-1:0]        TAP_TWO_RST  = 12'd2457;
    localparam logic signed [SAMPLE_W-1:0] FEEDBACK_RST = 16'sd26214;
    localparam logic [SAMPLE_W-1:0]        WET_RST      = 16'd32768;

    // Feedback limit of +-0.99 and unity wet, both in Q1.15.
    localparam logic signed [SAMPLE_W-1:0] FB_POS  = 16'sd32440;
    localparam logic signed [SAMPLE_W-1:0] FB_NEG  = -16'sd32440;
    localparam logic [SAMPLE_W-1:0]        WET_ONE = 16'd32768;

    // Output queue between the pipeline and the result channel.
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = 3;

    // Gain and wet mix as seen by each channel lane, already clamped.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gain;
        logic [SAMPLE_W-1:0]        wet;
    } mix_ctrl_t;

endpackage

@@ rtl/smfr_lane.sv @@
// Arithmetic pipeline of one channel: tap weighting, feedback scaling,
// rounding divide, write-back value and dry/wet mix. Uses smfr_pkg.
`timescale 1ns / 1ps

module smfr_lane (
    input  logic                                 clk,
    input  logic signed [smfr_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [smfr_pkg::SAMPLE_W-1:0] tap_base,
    input  logic signed [smfr_pkg::SAMPLE_W-1:0] tap_one,
    input  logic signed [smfr_pkg::SAMPLE_W-1:0] tap_two,
    input  smfr_pkg::mix_ctrl_t                  ctrl,
    output logic signed [smfr_pkg::SAMPLE_W-1:0] store_data,
    output logic signed [smfr_pkg::SAMPLE_W-1:0] result
);

    // (acc + 163840) / 327680 is done as a shift by 16 and a divide by 5.
    // The divide by 5 works on a value biased to be non-negative and uses
    // 838861 / 2^22, which is exact for inputs below 2^22.
    localparam logic signed [36:0] ROUND_TAP   = 37'sd163840;
    localparam logic signed [21:0] DIV5_BIAS   = 22'sd163840;
    localparam logic [38:0]        DIV5_RECIP  = 39'd838861;
    localparam logic signed [17:0] SUM_BIAS    = 18'sd32768;
    localparam logic signed [34:0] ROUND_MIX   = 35'sd16384;
    localparam logic signed [19:0] SAMPLE_MAX  = 20'sd32767;
    localparam logic signed [19:0] SAMPLE_MIN  = -20'sd32768;

    function automatic logic signed [15:0] sat_sample(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > SAMPLE_MAX)
        begin
            r = 16'sh7fff;
        end
        else if (v < SAMPLE_MIN)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic signed [15:0] s1_in_reg, s2_in_reg, s3_in_reg, s4_in_reg;
    logic signed [19:0] s2_t_reg,   s2_t_next;
    logic signed [35:0] s3_acc_reg, s3_acc_next;
    logic [38:0]        s4_prod_reg, s4_prod_next;
    logic signed [32:0] s5_dry_reg, s5_dry_next;
    logic signed [32:0] s5_wet_reg, s5_wet_next;

    logic signed [36:0] rnd;
    logic signed [21:0] biased;
    logic [16:0]        quot;
    logic signed [17:0] sum_wide;
    logic signed [15:0] sum;
    logic signed [17:0] diff;
    logic signed [16:0] dry_gain;
    logic signed [16:0] wet_gain;
    logic signed [34:0] mix;

    // Stage 1: weights 2, 3 and 5 on the three taps.
    always_comb
    begin
        s2_t_next = (20'(tap_base) <<< 1) + (20'(tap_one) <<< 1) + 20'(tap_one)
                  + (20'(tap_two) <<< 2) + 20'(tap_two);
    end

    // Stage 2: feedback gain.
    always_comb
    begin
        s3_acc_next = 36'($signed(ctrl.gain)) * 36'(s2_t_reg);
    end

    // Stage 3: shift, bias and reciprocal multiply.
    always_comb
    begin
        rnd          = 37'(s3_acc_reg) + ROUND_TAP;
        biased       = 22'($signed(rnd[36:16])) + DIV5_BIAS;
        s4_prod_next = 39'(biased[18:0]) * DIV5_RECIP;
    end

    // Stage 4: tap sum, write-back value and the two mix products.
    always_comb
    begin
        quot        = s4_prod_reg[38:22];
        sum_wide    = $signed({1'b0, quot}) - SUM_BIAS;
        // The tap sum stays inside the 16-bit range.
        sum         = sum_wide[15:0];
        diff        = 18'(s4_in_reg) - 18'(sum);
        store_data  = sat_sample(20'(diff));
        wet_gain    = $signed({1'b0, ctrl.wet});
        dry_gain    = $signed({1'b0, smfr_pkg::WET_ONE}) - wet_gain;
        s5_dry_next = 33'(s4_in_reg) * 33'(dry_gain);
        s5_wet_next = 33'(sum) * 33'(wet_gain);
    end

    // Stage 5: round, scale back to Q1.15 and saturate.
    always_comb
    begin
        mix    = 35'(s5_dry_reg) + 35'(s5_wet_reg) + ROUND_MIX;
        result = sat_sample(mix[34:15]);
    end

    always_ff @(posedge clk)
    begin
        s1_in_reg   <= sample;
        s2_in_reg   <= s1_in_reg;
        s2_t_reg    <= s2_t_next;
        s3_in_reg   <= s2_in_reg;
        s3_acc_reg  <= s3_acc_next;
        s4_in_reg   <= s3_in_reg;
        s4_prod_reg <= s4_prod_next;
        s5_dry_reg  <= s5_dry_next;
        s5_wet_reg  <= s5_wet_next;
    end

endmodule

@@ rtl/stereo_multitap_feedback_reverb.sv @@
// Top level of the stereo multitap feedback reverb: configuration registers,
// delay memories with forwarding, pipeline control and output queue.
// Uses smfr_pkg and smfr_lane.
`timescale 1ns / 1ps

// One stereo frame is taken per clock cycle while in_ready is high; a result
// that is not taken waits in an eight-entry output queue while the pipeline
// keeps taking frames until that queue is committed in full. Both channels
// share one delay memory word, held in two copies: one copy serves the base
// tap and the first offset tap, the other serves the second offset tap, so
// all three reads and the write-back happen in the same cycle. A tap that
// reads a slot still on its way in is served from the write path. The
// memories are not swept at reset: a fill count marks slots never written
// since reset, and those read as zero, so frames are taken from the first
// cycle after reset. Offsets are clamped to one to ninety-nine percent of
// the memory size, feedback to +-0.99, and wet to unity. Configuration
// writes are taken in any cycle but must only be issued while no frame is
// in flight.

module stereo_multitap_feedback_reverb #(
    parameter int DELAY_BITS = smfr_pkg::DELAY_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [smfr_pkg::SAMPLE_W-1:0]   left_sample,
    input  logic signed [smfr_pkg::SAMPLE_W-1:0]   right_sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [smfr_pkg::SAMPLE_W-1:0]   left_result,
    output logic signed [smfr_pkg::SAMPLE_W-1:0]   right_result,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [smfr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [smfr_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int DEPTH   = 1 << DELAY_BITS;
    localparam int MASK    = DEPTH - 1;
    localparam int CMP_W   = (DELAY_BITS > smfr_pkg::OFFSET_W) ? DELAY_BITS
                                                               : smfr_pkg::OFFSET_W;
    localparam logic [CMP_W-1:0] TAP_MIN = CMP_W'(MASK / 100);
    localparam logic [CMP_W-1:0] TAP_MAX = CMP_W'((MASK * 99) / 100);
    localparam logic [DELAY_BITS:0] FILL_FULL = (DELAY_BITS + 1)'(DEPTH);
    localparam int WORD_W  = 2 * smfr_pkg::SAMPLE_W;
    localparam int STAGES  = 5;
    localparam logic [smfr_pkg::OQ_PTR_W:0] OQ_FULL =
        (smfr_pkg::OQ_PTR_W + 1)'(smfr_pkg::OQ_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [smfr_pkg::OFFSET_W-1:0]        tap_one_reg, tap_two_reg;
    logic signed [smfr_pkg::SAMPLE_W-1:0] gain_reg;
    logic [smfr_pkg::SAMPLE_W-1:0]        wet_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_one_reg <= smfr_pkg::TAP_ONE_RST;
            tap_two_reg <= smfr_pkg::TAP_TWO_RST;
            gain_reg    <= smfr_pkg::FEEDBACK_RST;
            wet_reg     <= smfr_pkg::WET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                smfr_pkg::CFG_TAP_ONE:  tap_one_reg <= cfg_data[smfr_pkg::OFFSET_W-1:0];
                smfr_pkg::CFG_TAP_TWO:  tap_two_reg <= cfg_data[smfr_pkg::OFFSET_W-1:0];
                smfr_pkg::CFG_FEEDBACK: gain_reg    <= $signed(cfg_data);
                smfr_pkg::CFG_WET:      wet_reg     <= cfg_data;
                default:                tap_one_reg <= tap_one_reg;
            endcase
        end
    end

    logic [CMP_W-1:0]      off_one_wide, off_two_wide;
    logic [DELAY_BITS-1:0] off_one, off_two;
    smfr_pkg::mix_ctrl_t   ctrl;

    always_comb
    begin
        off_one_wide = CMP_W'(tap_one_reg);
        if (off_one_wide < TAP_MIN)
        begin
            off_one_wide = TAP_MIN;
        end
        else if (off_one_wide > TAP_MAX)
        begin
            off_one_wide = TAP_MAX;
        end
        off_two_wide = CMP_W'(tap_two_reg);
        if (off_two_wide < TAP_MIN)
        begin
            off_two_wide = TAP_MIN;
        end
        else if (off_two_wide > TAP_MAX)
        begin
            off_two_wide = TAP_MAX;
        end
        off_one = off_one_wide[DELAY_BITS-1:0];
        off_two = off_two_wide[DELAY_BITS-1:0];

        ctrl.gain = gain_reg;
        if (gain_reg > smfr_pkg::FB_POS)
        begin
            ctrl.gain = smfr_pkg::FB_POS;
        end
        else if (gain_reg < smfr_pkg::FB_NEG)
        begin
            ctrl.gain = smfr_pkg::FB_NEG;
        end
        ctrl.wet = (wet_reg > smfr_pkg::WET_ONE) ? smfr_pkg::WET_ONE : wet_reg;
    end

    // ------------------------------------------------------------------
    // Base pointer, read addresses and fill count
    // ------------------------------------------------------------------
    logic                  in_fire;
    logic [DELAY_BITS-1:0] base_reg;
    logic [DELAY_BITS:0]   fill_reg;
    logic [DELAY_BITS-1:0] pa [3];
    logic [2:0]            pa_ok;
    logic                  wr_en;

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        pa[0] = base_reg;
        pa[1] = base_reg + off_one;
        pa[2] = base_reg + off_two;
        // Writes run in address order starting one below zero, so a slot has
        // been written once its successor is below the fill count.
        for (int k = 0; k < 3; k++)
        begin
            pa_ok[k] = {1'b0, pa[k] + DELAY_BITS'(1)} < fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                base_reg <= base_reg + DELAY_BITS'(1);
            end
            if (wr_en && (fill_reg != FILL_FULL))
            begin
                fill_reg <= fill_reg + (DELAY_BITS + 1)'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: valid bits and write addresses per stage
    // ------------------------------------------------------------------
    logic [STAGES-1:0]     vld_reg;
    logic [DELAY_BITS-1:0] wa_reg [STAGES-1];
    logic [DELAY_BITS-1:0] s1_pa_reg [3];
    logic [2:0]            s1_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_fire};
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg[0] <= base_reg - DELAY_BITS'(1);
        for (int k = 1; k < STAGES - 1; k++)
        begin
            wa_reg[k] <= wa_reg[k-1];
        end
        for (int k = 0; k < 3; k++)
        begin
            s1_pa_reg[k] <= pa[k];
        end
        s1_ok_reg <= pa_ok;
    end

    // ------------------------------------------------------------------
    // Delay memories: two identical copies of {left, right} words
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]     mem_a [DEPTH];
    logic [WORD_W-1:0]     mem_b [DEPTH];
    logic [WORD_W-1:0]     rd_reg [3];
    logic [WORD_W-1:0]     wdata;
    logic [DELAY_BITS-1:0] waddr;

    assign wr_en = vld_reg[3];
    assign waddr = wa_reg[3];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[waddr] <= wdata;
            mem_b[waddr] <= wdata;
        end
        rd_reg[0] <= mem_a[pa[0]];
        rd_reg[1] <= mem_a[pa[1]];
        rd_reg[2] <= mem_b[pa[2]];
    end

    // The last write is kept so that a read issued on the same edge as that
    // write still sees the new value.
    logic                  lw_valid_reg;
    logic [DELAY_BITS-1:0] lw_addr_reg;
    logic [WORD_W-1:0]     lw_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lw_addr_reg <= waddr;
            lw_data_reg <= wdata;
        end
    end

    // Tap selection in stage 1: the write in progress is newest, then the
    // last completed write, then memory, and a slot never written reads zero.
    logic [WORD_W-1:0] tap_word [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (wr_en && (waddr == s1_pa_reg[k]))
            begin
                tap_word[k] = wdata;
            end
            else if (lw_valid_reg && (lw_addr_reg == s1_pa_reg[k]))
            begin
                tap_word[k] = lw_data_reg;
            end
            else if (s1_ok_reg[k])
            begin
                tap_word[k] = rd_reg[k];
            end
            else
            begin
                tap_word[k] = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Channel lanes
    // ------------------------------------------------------------------
    logic signed [smfr_pkg::SAMPLE_W-1:0] left_store, right_store;
    logic signed [smfr_pkg::SAMPLE_W-1:0] left_mix, right_mix;

    smfr_lane u_left (
        .clk        (clk),
        .sample     (left_sample),
        .tap_base   ($signed(tap_word[0][WORD_W-1:smfr_pkg::SAMPLE_W])),
        .tap_one    ($signed(tap_word[1][WORD_W-1:smfr_pkg::SAMPLE_W])),
        .tap_two    ($signed(tap_word[2][WORD_W-1:smfr_pkg::SAMPLE_W])),
        .ctrl       (ctrl),
        .store_data (left_store),
        .result     (left_mix)
    );

    smfr_lane u_right (
        .clk        (clk),
        .sample     (right_sample),
        .tap_base   ($signed(tap_word[0][smfr_pkg::SAMPLE_W-1:0])),
        .tap_one    ($signed(tap_word[1][smfr_pkg::SAMPLE_W-1:0])),
        .tap_two    ($signed(tap_word[2][smfr_pkg::SAMPLE_W-1:0])),
        .ctrl       (ctrl),
        .store_data (right_store),
        .result     (right_mix)
    );

    assign wdata = {left_store, right_store};

    // ------------------------------------------------------------------
    // Output queue and credit count
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]             oq_mem [smfr_pkg::OQ_DEPTH];
    logic [smfr_pkg::OQ_PTR_W-1:0] oq_wr_reg, oq_rd_reg;
    logic [smfr_pkg::OQ_PTR_W:0]   oq_count_reg, oq_count_next;
    logic [smfr_pkg::OQ_PTR_W:0]   credit_reg, credit_next;
    logic                          push, pop;

    assign push      = vld_reg[STAGES-1];
    assign out_valid = (oq_count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign in_ready  = (credit_reg < OQ_FULL);

    assign left_result  = $signed(oq_mem[oq_rd_reg][WORD_W-1:smfr_pkg::SAMPLE_W]);
    assign right_result = $signed(oq_mem[oq_rd_reg][smfr_pkg::SAMPLE_W-1:0]);

    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (push && !pop)
        begin
            oq_count_next = oq_count_reg + (smfr_pkg::OQ_PTR_W + 1)'(1);
        end
        else if (!push && pop)
        begin
            oq_count_next = oq_count_reg - (smfr_pkg::OQ_PTR_W + 1)'(1);
        end

        credit_next = credit_reg;
        if (in_fire && !pop)
        begin
            credit_next = credit_reg + (smfr_pkg::OQ_PTR_W + 1)'(1);
        end
        else if (!in_fire && pop)
        begin
            credit_next = credit_reg - (smfr_pkg::OQ_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
            credit_reg   <= '0;
        end
        else
        begin
            oq_count_reg <= oq_count_next;
            credit_reg   <= credit_next;
            if (push)
            begin
                oq_wr_reg <= oq_wr_reg + smfr_pkg::OQ_PTR_W'(1);
            end
            if (pop)
            begin
                oq_rd_reg <= oq_rd_reg + smfr_pkg::OQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            oq_mem[oq_wr_reg] <= {left_mix, right_mix};
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    // Every credited frame is either in the pipeline or in the queue.
    a_credit_balance: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg == (oq_count_reg + $countones(vld_reg)))
        else $error("credit count does not match frames in flight");

    a_base_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (base_reg == ($past(base_reg) + DELAY_BITS'(1))))
        else $error("base pointer did not advance on an input transfer");

    // Writes from frames still in stages 2 and 3 cannot be forwarded to stage 1.
    a_no_late_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && (vld_reg[1] || vld_reg[2])) |->
            !((vld_reg[1] && ((wa_reg[1] == s1_pa_reg[0]) || (wa_reg[1] == s1_pa_reg[1])
                              || (wa_reg[1] == s1_pa_reg[2])))
              || (vld_reg[2] && ((wa_reg[2] == s1_pa_reg[0])
                                 || (wa_reg[2] == s1_pa_reg[1])
                                 || (wa_reg[2] == s1_pa_reg[2])))))
        else $error("tap read overlaps a write that is not yet available");
`endif

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for stereo_multitap_feedback_reverb: a directed frame list, then
// random frames under a series of tap, feedback and wet settings, with random idling on both sides.
// Depends on smfr_pkg and the RTL of the block; results are checked against a local echo model.
`timescale 1ns / 1ps

module tb_top;
    import smfr_pkg::*;

    localparam int ECHO_BITS = DELAY_BITS_DEF;
    localparam int ECHO_DEPTH = 1 << ECHO_BITS;
    localparam int ECHO_MASK = ECHO_DEPTH - 1;
    localparam int OFFSET_FLOOR = ECHO_MASK / 100;
    localparam int OFFSET_CEIL = (ECHO_MASK * 99) / 100;
    localparam int NUM_SETTINGS = 8;
    localparam int FRAMES_PER_SETTING = 100;
    localparam int SETTLE_CYCLES = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } stereo_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    known;
        sample_t left_want;
        sample_t right_want;
    } opening_row_t;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    sample_t left_sample;
    sample_t right_sample;
    logic    out_valid;
    logic    out_ready;
    sample_t left_result;
    sample_t right_result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Local copy of the block state, advanced once per accepted frame.
    sample_t             echo_mem [2][ECHO_DEPTH];
    logic [ECHO_BITS-1:0] frame_ptr;
    logic [OFFSET_W-1:0]  tap_one_reg;
    logic [OFFSET_W-1:0]  tap_two_reg;
    sample_t             gain_reg;
    logic [SAMPLE_W-1:0] wet_reg;

    stereo_t echo_due [$];
    int      mismatches = 0;
    int      quiet_frames = 0;

    // Right after reset every tap reads zero and the mix is fully wet, so all outputs are zero.
    opening_row_t opening_rows [14] = '{
        '{16'sh7FFF, 16'sh7FFF, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh8000, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh0000, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh7FFF, 16'sh8000, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh7FFF, 1'b1, 16'sh0000, 16'sh0000},
        '{16'shFFFF, 16'sh0001, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh0001, 16'shFFFF, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh5555, 16'shAAAA, 1'b1, 16'sh0000, 16'sh0000},
        '{16'shAAAA, 16'sh5555, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh7FFF, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh0000, 16'sh8000, 1'b1, 16'sh0000, 16'sh0000},
        '{16'shFFFF, 16'shFFFF, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh4000, 16'shC000, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh00FF, 16'shFF00, 1'b1, 16'sh0000, 16'sh0000}
    };

    stereo_multitap_feedback_reverb u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_result  (left_result),
        .right_result (right_result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint floor_div(input longint num, input longint den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic sample_t sat16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return sample_t'(v);
    endfunction

    function automatic logic [ECHO_BITS-1:0] clamp_offset(input logic [OFFSET_W-1:0] off);
        if (off < OFFSET_FLOOR)
            return ECHO_BITS'(OFFSET_FLOOR);
        if (off > OFFSET_CEIL)
            return ECHO_BITS'(OFFSET_CEIL);
        return off;
    endfunction

    // One channel of one frame: three weighted taps, write-back behind the base, wet/dry mix.
    function automatic sample_t echo_channel(input int ch, input sample_t dry);
        longint gain;
        longint wet;
        longint acc;
        longint tap_sum;
        logic [ECHO_BITS-1:0] p0;
        logic [ECHO_BITS-1:0] p1;
        logic [ECHO_BITS-1:0] p2;
        logic [ECHO_BITS-1:0] pw;
        gain = gain_reg;
        if (gain > longint'(FB_POS))
            gain = longint'(FB_POS);
        if (gain < longint'(FB_NEG))
            gain = longint'(FB_NEG);
        wet = wet_reg;
        if (wet > longint'(WET_ONE))
            wet = longint'(WET_ONE);
        p0 = frame_ptr;
        p1 = frame_ptr + clamp_offset(tap_one_reg);
        p2 = frame_ptr + clamp_offset(tap_two_reg);
        pw = frame_ptr - 1'b1;
        acc = gain * (2 * longint'(echo_mem[ch][p0]) + 3 * longint'(echo_mem[ch][p1])
                      + 5 * longint'(echo_mem[ch][p2]));
        tap_sum = floor_div(acc + 163840, 327680);
        echo_mem[ch][pw] = sat16(longint'(dry) - tap_sum);
        return sat16(floor_div(longint'(dry) * (longint'(WET_ONE) - wet) + tap_sum * wet + 16384,
                               32768));
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return sample_t'(int'($urandom_range(0, 255)) - 128);
            default: return sample_t'($urandom());
        endcase
    endfunction

    // Offsets, feedback and wet for one block of random frames; the first few hit the clamps.
    function automatic void pick_setting(input int idx, output logic [CFG_DATA_W-1:0] t1,
                                         output logic [CFG_DATA_W-1:0] t2,
                                         output logic [CFG_DATA_W-1:0] fb,
                                         output logic [CFG_DATA_W-1:0] wet);
        case (idx)
            0:
            begin
                t1 = 16'd4054; t2 = 16'd4000; fb = FB_POS; wet = WET_ONE;
            end
            1:
            begin
                t1 = 16'hFFFF; t2 = 16'd4055; fb = 16'h7FFF; wet = 16'd0;
            end
            2:
            begin
                t1 = 16'd0; t2 = 16'd3950; fb = 16'h8000; wet = 16'd16384;
            end
            3:
            begin
                t1 = 16'd39; t2 = 16'd4095; fb = FB_NEG; wet = 16'hFFFF;
            end
            4:
            begin
                t1 = 16'd40; t2 = 16'd4054; fb = 16'd0; wet = 16'd32769;
            end
            5:
            begin
                t1 = {4'($urandom()), 12'($urandom_range(3900, 4095))};
                t2 = {4'($urandom()), 12'($urandom_range(3900, 4095))};
                fb = 16'($urandom());
                wet = 16'($urandom());
            end
            6:
            begin
                t1 = 16'd4030; t2 = 16'd2000; fb = -16'sd16384; wet = 16'd8192;
            end
            default:
            begin
                t1 = 16'($urandom());
                t2 = {4'($urandom()), 12'($urandom_range(3800, 4095))};
                fb = 16'($urandom());
                wet = 16'($urandom());
            end
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            if (took)
            begin
                case (idx)
                    CFG_TAP_ONE:  tap_one_reg = data[OFFSET_W-1:0];
                    CFG_TAP_TWO:  tap_two_reg = data[OFFSET_W-1:0];
                    CFG_FEEDBACK: gain_reg = data;
                    CFG_WET:      wet_reg = data;
                    default:      ;
                endcase
            end
            @(posedge clk);
        end
        while (!took);
    endtask

    // Offers one frame; the expectation is queued just before the accepting edge.
    task automatic send_frame(input sample_t l, input sample_t r, input logic known,
                              input sample_t l_want, input sample_t r_want);
        int unsigned gap;
        bit took;
        stereo_t due;
        if (quiet_frames != 0)
        begin
            quiet_frames--;
            gap = 0;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 29) == 0)
                quiet_frames = $urandom_range(20, 60);
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        left_sample <= l;
        right_sample <= r;
        do
        begin
            @(negedge clk);
            took = in_ready;
            if (took)
            begin
                due.left = echo_channel(0, l);
                due.right = echo_channel(1, r);
                frame_ptr = frame_ptr + 1'b1;
                if (known)
                begin
                    due.left = l_want;
                    due.right = r_want;
                end
                echo_due.push_back(due);
            end
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic wait_drained();
        while (echo_due.size() != 0)
            @(posedge clk);
    endtask

    // Result side: ready in bursts of random length, sometimes long stretches without a stall.
    initial
    begin : result_sink
        int unsigned gap;
        out_ready = 1'b0;
        forever
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(40, 100)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
            gap = pick_gap();
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        stereo_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (echo_due.size() == 0)
            begin
                $display("%0t ns: result with none pending, left %0d right %0d",
                         $time, left_result, right_result);
                mismatches++;
            end
            else
            begin
                want = echo_due.pop_front();
                if (left_result !== want.left)
                begin
                    $display("%0t ns: left_result expected %0d, actual %0d",
                             $time, want.left, left_result);
                    mismatches++;
                end
                if (right_result !== want.right)
                begin
                    $display("%0t ns: right_result expected %0d, actual %0d",
                             $time, want.right, right_result);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] t1;
        logic [CFG_DATA_W-1:0] t2;
        logic [CFG_DATA_W-1:0] fb;
        logic [CFG_DATA_W-1:0] wet;
        rst_n = 1'b0;
        in_valid = 1'b0;
        left_sample = '0;
        right_sample = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TAP_ONE;
        cfg_data = '0;
        for (int i = 0; i < ECHO_DEPTH; i++)
        begin
            echo_mem[0][i] = '0;
            echo_mem[1][i] = '0;
        end
        frame_ptr = '0;
        tap_one_reg = TAP_ONE_RST;
        tap_two_reg = TAP_TWO_RST;
        gain_reg = FEEDBACK_RST;
        wet_reg = WET_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_rows[i])
            send_frame(opening_rows[i].left, opening_rows[i].right, opening_rows[i].known,
                       opening_rows[i].left_want, opening_rows[i].right_want);
        in_valid <= 1'b0;

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            wait_drained();
            pick_setting(s, t1, t2, fb, wet);
            write_reg(CFG_TAP_ONE, t1);
            write_reg(CFG_TAP_TWO, t2);
            write_reg(CFG_FEEDBACK, fb);
            write_reg(CFG_WET, wet);
            cfg_valid <= 1'b0;
            repeat (FRAMES_PER_SETTING)
                send_frame(pick_sample(), pick_sample(), 1'b0, '0, '0);
            in_valid <= 1'b0;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/smfr_pkg.sv
rtl/smfr_lane.sv
rtl/stereo_multitap_feedback_reverb.sv
test/tb_top.sv
